// File: rtl/core/skvt_pkg.sv
// Shared codes and the control bundle for the sorted key/value table.
package skvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_ABSENT  = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_UPDATE = 2'd3;

   typedef struct packed {
      logic                      capture;
      logic [1:0]                op;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

// File: rtl/core/skvt_cell.sv
// One slot of the sorted row: holds a pair, compares against the broadcast key, shifts.
module skvt_cell
   import skvt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctrl_type             ctrl,
   input  logic                      slot_valid,
   input  logic                      prev_above,
   input  logic signed [KEY_W-1:0]   prev_key,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic signed [KEY_W-1:0]   next_key,
   input  logic signed [VALUE_W-1:0] next_value,
   output logic signed [KEY_W-1:0]   key,
   output logic signed [VALUE_W-1:0] value,
   output logic                      above,
   output logic                      match
);

   logic signed [KEY_W-1:0]   key_ff, key_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      above_ff, above_in;
   logic                      match_ff, match_in;

   // above: slot sits at or past the insertion point (key >= probe, or empty)
   always_comb begin
      above_in = above_ff;
      match_in = match_ff;
      if (ctrl.capture) begin
         above_in = !slot_valid || (key_ff >= ctrl.key);
         match_in = slot_valid && (key_ff == ctrl.key);
      end
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (above_ff) begin
               if (prev_above) begin
                  key_in   = prev_key;
                  value_in = prev_value;
               end else begin
                  key_in   = ctrl.key;
                  value_in = ctrl.value;
               end
            end
         end
         CELL_REMOVE: begin
            if (above_ff) begin
               key_in   = next_key;
               value_in = next_value;
            end
         end
         CELL_UPDATE: begin
            if (match_ff) begin
               value_in = ctrl.value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         above_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         above_ff <= above_in;
         match_ff <= match_in;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign above = above_ff;
   assign match = match_ff;

endmodule

// File: rtl/core/sorted_key_value_table.sv
// Sorted key/value table: a row of CAPACITY cells kept in ascending signed key order.
// Each command is compared, then applied across the row, which registers its response.
// A new command is accepted only as the current one retires from apply.
// Apply stalls only while a previous response is still waiting to be taken.
// Reset (synchronous, active high) empties the table; slot contents are not cleared.
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] key, [63:32] value
   input  logic [1:0]  req_tuser,  // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [1:0] status, [8:2] entry_count, [15:9] zero
);

   localparam int OCC_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [1:0]                cmd_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                status_ff, status_in;
   logic [COUNT_W-1:0]        count_ff;

   logic                      out_free;
   logic                      apply_fire;
   logic                      req_fire;
   logic                      hit;
   logic                      full;
   logic [1:0]                op_sel;
   logic [31:0]               occ_wide;
   cell_ctrl_type             ctrl;

   logic signed [KEY_W-1:0]   cell_key   [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       above_vec;
   logic [CAPACITY-1:0]       match_vec;

   // output register frees when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign apply_fire = (state_ff == S_APPLY) && out_free;
   // a new command may enter on the cycle the current one retires
   assign req_tready = (state_ff == S_IDLE) || apply_fire;
   assign req_fire   = req_tvalid && req_tready;

   // keys are unique, so at most one slot matches
   assign hit  = |match_vec;
   assign full = (occ_ff == OCC_W'(CAPACITY));

   always_comb begin
      status_in = STATUS_DONE;
      op_sel    = CELL_HOLD;
      occ_in    = occ_ff;
      case (cmd_ff)
         CMD_INSERT: begin
            if (hit) begin
               status_in = STATUS_PRESENT;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               op_sel = CELL_INSERT;
               occ_in = occ_ff + OCC_W'(1);
            end
         end
         CMD_UPDATE: begin
            if (hit) begin
               op_sel = CELL_UPDATE;
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               op_sel = CELL_REMOVE;
               occ_in = occ_ff - OCC_W'(1);
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         CMD_CLEAR: begin
            occ_in = '0;
         end
         default: begin
         end
      endcase
   end

   // broadcast to the row: capture compare flags in S_CMP, shift/write on apply
   always_comb begin
      ctrl.capture = (state_ff == S_CMP);
      ctrl.op      = apply_fire ? op_sel : CELL_HOLD;
      ctrl.key     = key_ff;
      ctrl.value   = value_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) begin
               state_in = req_fire ? S_CMP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign occ_wide = 32'(occ_in);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tuser;
         key_ff   <= req_tdata[31:0];
         value_ff <= req_tdata[63:32];
      end
      if (apply_fire) begin
         status_ff <= status_in;
         count_ff  <= occ_wide[COUNT_W-1:0];
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_fire) begin
            occ_ff <= occ_in;
         end
      end
   end

   // the row of cells; neighbours pass data up on insert and down on remove
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      slot_valid;
      logic                      prev_above;
      logic signed [KEY_W-1:0]   prev_key;
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [KEY_W-1:0]   next_key;
      logic signed [VALUE_W-1:0] next_value;

      assign slot_valid = (OCC_W'(i) < occ_ff);

      if (i == 0) begin : g_first
         assign prev_above = 1'b0;
         assign prev_key   = '0;
         assign prev_value = '0;
      end else begin : g_link_prev
         assign prev_above = above_vec[i-1];
         assign prev_key   = cell_key[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_key   = cell_key[i];
         assign next_value = cell_value[i];
      end else begin : g_link_next
         assign next_key   = cell_key[i+1];
         assign next_value = cell_value[i+1];
      end

      skvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .slot_valid (slot_valid),
         .prev_above (prev_above),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .next_key   (next_key),
         .next_value (next_value),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .above      (above_vec[i]),
         .match      (match_vec[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, count_ff, status_ff};

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(CAPACITY))
      else $error("entry count above capacity");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one slot matches the key");

   a_cmp_to_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |=> (state_ff == S_APPLY))
      else $error("compare not followed by apply");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (apply_fire && (op_sel == CELL_INSERT)) |=> (occ_ff == $past(occ_ff) + OCC_W'(1)))
      else $error("insert did not grow the table");

endmodule

// File: sim/tb_sorted_key_value_table.sv
// Self-checking testbench for the sorted key/value table: directed and random commands.
module tb_sorted_key_value_table;
   import skvt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int POOL_SIZE   = 100;
   localparam int PHASE_ITEMS = 332;

   typedef struct {
      logic [1:0]                cmd;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } command_item;

   typedef struct {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } response_item;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_kind;

   // Shadow copy of the table: predicts each response and checks it on arrival.
   class table_tracker;
      logic signed [KEY_W-1:0]   shadow_keys[TABLE_DEPTH];
      logic signed [VALUE_W-1:0] shadow_values[TABLE_DEPTH];
      int                        held;
      response_item              awaited[$];
      int                        mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      task log_mismatch(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Apply one accepted command to the shadow table and queue its response.
      function void note_command(input command_item it);
         response_item r;
         int           pos;
         logic         hit;
         r.status = STATUS_DONE;
         pos = 0;
         while (pos < held && shadow_keys[pos] < it.key)
            pos++;
         hit = (pos < held) && (shadow_keys[pos] == it.key);
         case (it.cmd)
            CMD_CLEAR: begin
               held = 0;
            end
            CMD_INSERT: begin
               if (hit) begin
                  r.status = STATUS_PRESENT;
               end else if (held >= TABLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  for (int i = held; i > pos; i--) begin
                     shadow_keys[i]   = shadow_keys[i-1];
                     shadow_values[i] = shadow_values[i-1];
                  end
                  shadow_keys[pos]   = it.key;
                  shadow_values[pos] = it.value;
                  held++;
               end
            end
            CMD_UPDATE: begin
               if (hit)
                  shadow_values[pos] = it.value;
               else
                  r.status = STATUS_ABSENT;
            end
            default: begin
               if (hit) begin
                  for (int i = pos; i + 1 < held; i++) begin
                     shadow_keys[i]   = shadow_keys[i+1];
                     shadow_values[i] = shadow_values[i+1];
                  end
                  held--;
               end else begin
                  r.status = STATUS_ABSENT;
               end
            end
         endcase
         r.count = COUNT_W'(held);
         awaited.push_back(r);
      endfunction

      task check_response(input logic [1:0] status, input logic [COUNT_W-1:0] count);
         response_item want;
         if (awaited.size() == 0) begin
            log_mismatch($sformatf("response with nothing outstanding (status %0d count %0d)",
                                   status, count));
         end else begin
            want = awaited.pop_front();
            if (status !== want.status)
               log_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (count !== want.count)
               log_mismatch($sformatf("entry_count %0d, expected %0d", count, want.count));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;  // [31:0] key, [63:32] value
   logic [1:0]  req_tuser  = '0;  // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [1:0] status, [8:2] entry_count, [15:9] zero

   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
   table_tracker            tracker = new();

   sorted_key_value_table #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Response side: check each transfer, then choose whether to stall next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tdata[1:0], rsp_tdata[8:2]);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one command, idling at random first, and record it once transferred.
   task automatic send(input command_item it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {it.value, it.key};
      do @(posedge clock); while (!req_tready);
      tracker.note_command(it);
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic signed [KEY_W-1:0] key,
                              input logic signed [VALUE_W-1:0] value);
      command_item it;
      it.cmd   = cmd;
      it.key   = key;
      it.value = value;
      send(it);
   endtask

   // Hold the request side quiet until every response has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   // Mostly pool keys so that hits, a full table and drains all happen; some pure noise.
   function automatic command_item make_random(input mix_kind mix);
      command_item it;
      int          p;
      it.value = $urandom;
      if ($urandom_range(99) < 12) begin
         it.cmd = 2'($urandom);
         it.key = $urandom;
         return it;
      end
      it.key = key_pool[$urandom_range(POOL_SIZE-1)];
      p = $urandom_range(99);
      case (mix)
         MIX_FILL:
            it.cmd = (p < 85) ? CMD_INSERT : (p < 92) ? CMD_UPDATE : CMD_REMOVE;
         MIX_BALANCED:
            it.cmd = (p < 40) ? CMD_INSERT : (p < 65) ? CMD_UPDATE :
                     (p < 97) ? CMD_REMOVE : CMD_CLEAR;
         default:
            it.cmd = (p < 15) ? CMD_INSERT : (p < 30) ? CMD_UPDATE :
                     (p < 98) ? CMD_REMOVE : CMD_CLEAR;
      endcase
      return it;
   endfunction

   initial begin
      #2000000;
      $display("tb_sorted_key_value_table NOT OK");
      $finish;
   end

   initial begin
      mix_kind mix;
      int      seg;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = 0;
      key_pool[3] = -1;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme keys, duplicates, misses, first/middle/last removal
      send_fields(CMD_UPDATE, 5, 1);
      send_fields(CMD_REMOVE, 5, 1);
      send_fields(CMD_CLEAR, 32'sh7FFF_FFFF, -1);
      send_fields(CMD_INSERT, 0, 32'sh8000_0000);
      send_fields(CMD_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_fields(CMD_INSERT, 32'sh8000_0000, 0);
      send_fields(CMD_INSERT, -1, -1);
      send_fields(CMD_INSERT, 0, 12345);
      send_fields(CMD_UPDATE, -1, 32'sh5555_AAAA);
      send_fields(CMD_UPDATE, 7, 3);
      send_fields(CMD_REMOVE, 0, -1);
      send_fields(CMD_REMOVE, 0, 0);
      send_fields(CMD_REMOVE, 32'sh8000_0000, 0);
      send_fields(CMD_REMOVE, 32'sh7FFF_FFFF, 0);
      send_fields(CMD_INSERT, 1, 11);
      send_fields(CMD_INSERT, 2, 22);
      send_fields(CMD_INSERT, 32'sh8000_0001, 33);
      send_fields(CMD_UPDATE, 32'sh8000_0001, 32'sh8000_0000);
      send_fields(CMD_CLEAR, 0, 0);
      send_fields(CMD_REMOVE, -1, 0);
      send_fields(CMD_UPDATE, 1, 0);
      send_fields(CMD_INSERT, -1, -1);
      settle();

      // random phases: no idling, sender gaps, receiver stalls, both lightly
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 7 : 0;
         recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 7 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            seg = n % 166;
            mix = (seg < 70) ? MIX_FILL : (seg < 120) ? MIX_BALANCED : MIX_DRAIN;
            if (ph == 1 && n == 150)
               settle();
            send(make_random(mix));
         end
         settle();
      end

      repeat (6) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("tb_sorted_key_value_table OK");
      else
         $display("tb_sorted_key_value_table NOT OK");
      $finish;
   end

endmodule
